### rtl/core/gpfifo_channel_submitter_defines.svh
// Shared assertion macros for the channel submitter RTL.
`ifndef GPFIFO_CHANNEL_SUBMITTER_DEFINES_SVH
`define GPFIFO_CHANNEL_SUBMITTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define GFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define GFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gfs_pkg.sv
package gfs_pkg;

  localparam int unsigned PB_BYTES_DFLT     = 4096;
  localparam int unsigned RING_ENTRIES_DFLT = 512;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned VA_BITS           = 40;

  // request kinds on the input channel
  localparam logic [1:0] ACT_RESERVE = 2'd0;
  localparam logic [1:0] ACT_REWIND  = 2'd1;
  localparam logic [1:0] ACT_SUBMIT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_READY = 2'd0;
  localparam logic [1:0] CFG_PB_BASE       = 2'd1;
  localparam logic [1:0] CFG_DB_ENABLED    = 2'd2;
  localparam logic [1:0] CFG_DB_TOKEN      = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_HOST_BUSY = 3'd3;
  localparam logic [2:0] ST_ADDR_HIGH = 3'd4;

  typedef enum logic [1:0] {
    K_RESERVE,
    K_REWIND,
    K_SUBMIT,
    K_FAIL
  } kind_t;

  // classified request handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  status;      // failure code when kind is K_FAIL
    logic [15:0] rbytes;
    logic [31:0] host_get;
    logic [31:0] entry_low;
    logic [31:0] entry_high;
    logic [12:0] put_bytes;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] granted_offset;
    logic [8:0]  ring_slot;
    logic [31:0] entry_low;
    logic [31:0] entry_high;
    logic [31:0] new_put_count;
    logic [12:0] new_put_bytes;
    logic        doorbell_kick;
  } res_t;

endpackage

### rtl/core/gpfifo_channel_submitter.sv
// Command channel pushbuffer / ring entry submitter.
// Input channel (in_valid/in_ready) takes one request per cycle: reserve,
// rewind or submit, with all fields valid on every request. Result channel
// (out_valid/out_ready) returns exactly one result per request, in order,
// carrying a status code and the reserve grant or the submit ring entry.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes the channel-ready flag,
// pushbuffer base, doorbell enable and doorbell token; write only while idle.
// A request passes through the classify register, the request queue and
// the result register before its result is valid.
// Throughput: one request per cycle while out_ready stays high; the back
// end updates fill position and put count as each request is taken.
// Reset clears configuration, fill position and put count; no result is
// pending afterwards. When out_ready is low the result register holds, the
// queue and the front register take up to three more requests, then
// in_ready drops until the receiver takes a result.
module gpfifo_channel_submitter #(
  parameter int unsigned PB_BYTES     = gfs_pkg::PB_BYTES_DFLT,
  parameter int unsigned RING_ENTRIES = gfs_pkg::RING_ENTRIES_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_reserve_bytes,
  input  logic [15:0] in_submit_offset,
  input  logic [15:0] in_submit_length,
  input  logic [31:0] in_host_get,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [12:0] out_granted_offset,
  output logic [8:0]  out_ring_slot,
  output logic [31:0] out_entry_low,
  output logic [31:0] out_entry_high,
  output logic [31:0] out_new_put_count,
  output logic [12:0] out_new_put_bytes,
  output logic        out_doorbell_kick
);
  import gfs_pkg::*;

  logic        chan_rdy_r;
  logic [47:0] pb_base_r;
  logic        db_en_r;
  logic        fq_valid, fq_ready;
  req_t        fq_req;
  logic        qb_valid, qb_ready;
  req_t        qb_req;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_rdy_r <= 1'b0;
      pb_base_r  <= '0;
      db_en_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_READY: chan_rdy_r <= cfg_wdata[0];
        CFG_PB_BASE:       pb_base_r  <= cfg_wdata;
        CFG_DB_ENABLED:    db_en_r    <= cfg_wdata[0];
        CFG_DB_TOKEN:      ; // token is not stored in this block
        default:           ;
      endcase
    end
  end

  gfs_front #(
    .PB_BYTES (PB_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_reserve_bytes (in_reserve_bytes),
    .in_submit_offset (in_submit_offset),
    .in_submit_length (in_submit_length),
    .in_host_get      (in_host_get),
    .channel_ready    (chan_rdy_r),
    .pb_base          (pb_base_r),
    .req_valid        (fq_valid),
    .req_ready        (fq_ready),
    .req              (fq_req)
  );

  gfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_req),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_req)
  );

  gfs_back #(
    .PB_BYTES     (PB_BYTES),
    .RING_ENTRIES (RING_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (qb_valid),
    .req_ready        (qb_ready),
    .req              (qb_req),
    .doorbell_enabled (db_en_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .res              (res)
  );

  assign out_status         = res.status;
  assign out_granted_offset = res.granted_offset;
  assign out_ring_slot      = res.ring_slot;
  assign out_entry_low      = res.entry_low;
  assign out_entry_high     = res.entry_high;
  assign out_new_put_count  = res.new_put_count;
  assign out_new_put_bytes  = res.new_put_bytes;
  assign out_doorbell_kick  = res.doorbell_kick;

endmodule

### rtl/core/gfs_front.sv
module gfs_front #(
  parameter int unsigned PB_BYTES = gfs_pkg::PB_BYTES_DFLT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [15:0]       in_reserve_bytes,
  input  logic [15:0]       in_submit_offset,
  input  logic [15:0]       in_submit_length,
  input  logic [31:0]       in_host_get,
  input  logic              channel_ready,
  input  logic [47:0]       pb_base,
  output logic              req_valid,
  input  logic              req_ready,
  output gfs_pkg::req_t     req
);
  import gfs_pkg::*;

  `include "gpfifo_channel_submitter_defines.svh"

  logic        fv_r;
  req_t        req_r;
  req_t        dec;
  logic [16:0] range_end;
  logic [48:0] addr;
  logic [16:0] len_p3;

  assign range_end = {1'b0, in_submit_offset} + {1'b0, in_submit_length};
  assign addr      = {1'b0, pb_base} + 49'(in_submit_offset);
  assign len_p3    = {1'b0, in_submit_length} + 17'd3;

  always_comb begin
    dec            = '0;
    dec.rbytes     = in_reserve_bytes;
    dec.host_get   = in_host_get;
    dec.entry_low  = {addr[31:2], 2'b00};
    // sync 31 = 0, dword count at 30:10, level 9 = 0, addr 39:32 at 7:0
    dec.entry_high = {1'b0, 6'b0, len_p3[16:2], 1'b0, 1'b0, addr[39:32]};
    dec.put_bytes  = range_end[12:0];
    dec.kind       = K_FAIL;
    dec.status     = ST_NO_SPACE;
    if (!channel_ready) begin
      dec.status = ST_NOT_READY;
    end else begin
      unique case (in_action)
        ACT_RESERVE: dec.kind = K_RESERVE;
        ACT_REWIND:  dec.kind = K_REWIND;
        ACT_SUBMIT: begin
          if (in_submit_length == 16'd0 || range_end > 17'(PB_BYTES)) begin
            dec.status = ST_NO_SPACE;
          end else if (addr[48:VA_BITS] != '0) begin
            dec.status = ST_ADDR_HIGH;
          end else begin
            dec.kind = K_SUBMIT;
          end
        end
        default: dec.status = ST_NO_SPACE;
      endcase
    end
  end

  assign in_ready  = !fv_r || req_ready;
  assign req_valid = fv_r;
  assign req       = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= dec;
    end
  end

  `GFS_ASSERT_IMP(a_fail_has_code, fv_r && req_r.kind == K_FAIL, req_r.status != ST_OK, "failed request without error code")

endmodule

### rtl/core/gfs_queue.sv
module gfs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  gfs_pkg::req_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output gfs_pkg::req_t pop_data
);
  import gfs_pkg::*;

  `include "gpfifo_channel_submitter_defines.svh"

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  req_t            mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            push;
  logic            pop;

  assign push_ready = cnt_r != CntW'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `GFS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CntW'(QUEUE_DEPTH), "queue count past depth")
  `GFS_ASSERT_NXT(a_cnt_hold, !push && !pop, $stable(cnt_r), "queue count moved while idle")

endmodule

### rtl/core/gfs_back.sv
module gfs_back #(
  parameter int unsigned PB_BYTES     = gfs_pkg::PB_BYTES_DFLT,
  parameter int unsigned RING_ENTRIES = gfs_pkg::RING_ENTRIES_DFLT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  gfs_pkg::req_t req,
  input  logic          doorbell_enabled,
  output logic          out_valid,
  input  logic          out_ready,
  output gfs_pkg::res_t res
);
  import gfs_pkg::*;

  `include "gpfifo_channel_submitter_defines.svh"

  localparam int unsigned FW   = $clog2(PB_BYTES + 1);
  localparam int unsigned RW   = $clog2(RING_ENTRIES);
  localparam int unsigned SumW = ((FW + 1) > 16 ? (FW + 1) : 16) + 1;

  logic [FW-1:0]   fill_r, fill_nxt;
  logic [31:0]     put_r, put_nxt;
  logic [RW-1:0]   slot_r, slot_nxt;
  logic            ov_r;
  res_t            res_r, res_nxt;
  logic [SumW-1:0] aligned;
  logic [SumW-1:0] end_pos;
  logic [31:0]     slot_ext;
  logic            pop;

  // round fill position up to a dword, then check the grant fits
  assign aligned  = (SumW'(fill_r) + SumW'(3)) & ~SumW'(3);
  assign end_pos  = aligned + SumW'(req.rbytes);
  assign slot_ext = 32'(slot_r);

  assign req_ready = !ov_r || out_ready;
  assign pop       = req_valid && req_ready;
  assign out_valid = ov_r;
  assign res       = res_r;

  always_comb begin
    res_nxt  = '0;
    fill_nxt = fill_r;
    put_nxt  = put_r;
    slot_nxt = slot_r;
    unique case (req.kind)
      K_RESERVE: begin
        if (end_pos <= SumW'(PB_BYTES)) begin
          res_nxt.status         = ST_OK;
          res_nxt.granted_offset = aligned[12:0];
          fill_nxt               = end_pos[FW-1:0];
        end else begin
          res_nxt.status = ST_NO_SPACE;
        end
      end
      K_REWIND: begin
        if (fill_r != '0 && req.host_get != put_r) begin
          res_nxt.status = ST_HOST_BUSY;
        end else begin
          res_nxt.status = ST_OK;
          fill_nxt       = '0;
        end
      end
      K_SUBMIT: begin
        // slot_r tracks put_r modulo the ring size
        put_nxt                = put_r + 32'd1;
        slot_nxt               = (slot_r == RW'(RING_ENTRIES - 1)) ? '0 : slot_r + 1'b1;
        res_nxt.status         = ST_OK;
        res_nxt.ring_slot      = slot_ext[8:0];
        res_nxt.entry_low      = req.entry_low;
        res_nxt.entry_high     = req.entry_high;
        res_nxt.new_put_count  = put_nxt;
        res_nxt.new_put_bytes  = req.put_bytes;
        res_nxt.doorbell_kick  = doorbell_enabled;
      end
      K_FAIL: res_nxt.status = req.status;
      default: res_nxt.status = req.status;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      put_r  <= '0;
      slot_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (req_ready) begin
        ov_r <= req_valid;
      end
      if (pop) begin
        fill_r <= fill_nxt;
        put_r  <= put_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  `GFS_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= FW'(PB_BYTES), "fill position past pushbuffer end")
  `GFS_ASSERT_IMP(a_slot_bound, 1'b1, slot_r <= RW'(RING_ENTRIES - 1), "ring slot out of range")
  `GFS_ASSERT_NXT(a_put_hold, !(pop && req.kind == K_SUBMIT), $stable(put_r), "put count moved without submit")

endmodule

### dv/gfs_tb_pkg.sv
package gfs_tb_pkg;
  import gfs_pkg::*;

  // action code with no request kind behind it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  class channel_scoreboard;
    bit          chan_ready;
    bit [47:0]   pb_base;
    bit          db_enabled;
    bit [31:0]   db_token;    // held only, no result carries it
    int unsigned fill_pos;
    bit [31:0]   put_count;
    res_t        due_results[$];
    int unsigned errors;

    function void write_reg(logic [1:0] idx, logic [47:0] data);
      case (idx)
        CFG_CHANNEL_READY: chan_ready = data[0];
        CFG_PB_BASE:       pb_base    = data;
        CFG_DB_ENABLED:    db_enabled = data[0];
        CFG_DB_TOKEN:      db_token   = data[31:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(logic [1:0] act, logic [15:0] rbytes, logic [15:0] soff,
                               logic [15:0] slen, logic [31:0] hget);
      res_t        r;
      int unsigned off, len, grant, dwords, put_end;
      bit   [48:0] addr;
      bit   [31:0] slot;
      r = '0;
      r.status = ST_OK;
      off = 32'(soff);
      len = 32'(slen);
      if (!chan_ready) begin
        r.status = ST_NOT_READY;
      end else begin
        case (act)
          ACT_RESERVE: begin
            grant = (fill_pos + 3) & ~32'd3;
            if (grant + rbytes > PB_BYTES_DFLT) begin
              r.status = ST_NO_SPACE;
            end else begin
              fill_pos = grant + rbytes;
              r.granted_offset = grant[12:0];
            end
          end
          ACT_REWIND: begin
            // host_get only matters while something is in the pushbuffer
            if (fill_pos != 0 && hget != put_count) r.status = ST_HOST_BUSY;
            else fill_pos = 0;
          end
          ACT_SUBMIT: begin
            addr = pb_base + off;
            if (len == 0 || off + len > PB_BYTES_DFLT) begin
              r.status = ST_NO_SPACE;
            end else if ((addr >> VA_BITS) != 0) begin
              r.status = ST_ADDR_HIGH;
            end else begin
              slot    = put_count % RING_ENTRIES_DFLT;
              dwords  = (len + 3) / 4;
              put_end = off + len;
              r.ring_slot  = slot[8:0];
              r.entry_low  = {addr[31:2], 2'b00};
              // sync 0, dword length, level 0, spare bit, address 39:32
              r.entry_high = {1'b0, dwords[20:0], 2'b00, addr[39:32]};
              put_count = put_count + 1;
              r.new_put_count = put_count;
              r.new_put_bytes = put_end[12:0];
              r.doorbell_kick = db_enabled;
            end
          end
          default: r.status = ST_NO_SPACE;
        endcase
      end
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", got.status);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("status",         want.status,         got.status);
      compare_field("granted_offset", want.granted_offset, got.granted_offset);
      compare_field("ring_slot",      want.ring_slot,      got.ring_slot);
      compare_field("entry_low",      want.entry_low,      got.entry_low);
      compare_field("entry_high",     want.entry_high,     got.entry_high);
      compare_field("new_put_count",  want.new_put_count,  got.new_put_count);
      compare_field("new_put_bytes",  want.new_put_bytes,  got.new_put_bytes);
      compare_field("doorbell_kick",  want.doorbell_kick,  got.doorbell_kick);
    endfunction
  endclass

endpackage

### dv/tb_gpfifo_channel_submitter.sv
module tb_gpfifo_channel_submitter;
  timeunit 1ns;
  timeprecision 1ps;

  import gfs_pkg::*;
  import gfs_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [15:0] in_reserve_bytes = '0;
  logic [15:0] in_submit_offset = '0;
  logic [15:0] in_submit_length = '0;
  logic [31:0] in_host_get = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [12:0] out_granted_offset;
  logic [8:0]  out_ring_slot;
  logic [31:0] out_entry_low;
  logic [31:0] out_entry_high;
  logic [31:0] out_new_put_count;
  logic [12:0] out_new_put_bytes;
  logic        out_doorbell_kick;

  channel_scoreboard sb;
  res_t              seen;
  bit                sender_idle = 1'b0;
  bit                sink_idle = 1'b0;
  bit                sink_hold_req = 1'b0;
  int unsigned       cycle_count = 0;

  gpfifo_channel_submitter u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_reserve_bytes   (in_reserve_bytes),
    .in_submit_offset   (in_submit_offset),
    .in_submit_length   (in_submit_length),
    .in_host_get        (in_host_get),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_granted_offset (out_granted_offset),
    .out_ring_slot      (out_ring_slot),
    .out_entry_low      (out_entry_low),
    .out_entry_high     (out_entry_high),
    .out_new_put_count  (out_new_put_count),
    .out_new_put_bytes  (out_new_put_bytes),
    .out_doorbell_kick  (out_doorbell_kick)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  assign seen = {out_status, out_granted_offset, out_ring_slot, out_entry_low,
                 out_entry_high, out_new_put_count, out_new_put_bytes, out_doorbell_kick};

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 93) return $urandom_range(3, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(seen);
  end

  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else if (stall == 0 && sink_idle && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_request(input logic [1:0] act, input logic [15:0] rbytes,
                              input logic [15:0] soff, input logic [15:0] slen,
                              input logic [31:0] hget);
    in_valid         <= 1'b1;
    in_action        <= act;
    in_reserve_bytes <= rbytes;
    in_submit_offset <= soff;
    in_submit_length <= slen;
    in_host_get      <= hget;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, rbytes, soff, slen, hget);
  endtask

  task automatic pause_sender(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all four registers back to back; only called while idle
  task automatic apply_config(input bit ready, input logic [47:0] base,
                              input bit db_en, input logic [31:0] token);
    logic [47:0] vals [4];
    logic [1:0]  idx [4];
    vals[0] = {47'd0, ready};  idx[0] = CFG_CHANNEL_READY;
    vals[1] = base;            idx[1] = CFG_PB_BASE;
    vals[2] = {47'd0, db_en};  idx[2] = CFG_DB_ENABLED;
    vals[3] = {16'd0, token};  idx[3] = CFG_DB_TOKEN;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(input int unsigned submit_pct);
    logic [1:0]  act;
    logic [15:0] rbytes, soff, slen;
    logic [31:0] hget;
    int unsigned pick, rest, room;
    rbytes = 16'($urandom);
    soff   = 16'($urandom);
    slen   = 16'($urandom);
    hget   = $urandom;
    rest   = 97 - submit_pct;
    pick   = $urandom_range(0, 99);
    if (pick < submit_pct) act = ACT_SUBMIT;
    else if (pick < submit_pct + rest * 2 / 3) act = ACT_RESERVE;
    else if (pick < 97) act = ACT_REWIND;
    else act = ACT_UNUSED;
    pick = $urandom_range(0, 99);
    case (act)
      ACT_RESERVE: begin
        if (pick < 65) rbytes = 16'($urandom_range(0, 96));
        else if (pick < 90) rbytes = 16'($urandom_range(0, PB_BYTES_DFLT));
      end
      ACT_REWIND: begin
        if (pick < 80) hget = sb.put_count;
      end
      ACT_SUBMIT: begin
        if (pick < 80) begin
          soff = 16'($urandom_range(0, PB_BYTES_DFLT - 1));
          room = PB_BYTES_DFLT - soff;
          if ($urandom_range(0, 1) == 0) slen = 16'($urandom_range(1, room));
          else slen = 16'($urandom_range(1, room < 64 ? room : 64));
        end else if (pick < 88) begin
          soff = 16'($urandom_range(0, PB_BYTES_DFLT - 1));
          slen = '0;
        end
      end
      default: ;
    endcase
    send_request(act, rbytes, soff, slen, hget);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned submit_pct,
                            input bit idle);
    int unsigned gap;
    sender_idle = idle;
    sink_idle   = idle;
    repeat (count) begin
      send_random(submit_pct);
      gap = sender_idle ? pick_gap() : 0;
      if (gap > 0) pause_sender(gap);
    end
  endtask

  initial begin : stimulus
    logic [47:0] base;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // channel still down after reset: everything is refused
    send_request(ACT_RESERVE, 16'd4, '0, '0, '0);
    send_request(ACT_SUBMIT, '0, '0, 16'd4, '0);
    send_request(ACT_REWIND, '0, '0, '0, '0);
    send_request(ACT_UNUSED, '0, '0, '0, '0);
    wait_drained();

    apply_config(1'b1, '0, 1'b1, 32'hffff_ffff);
    send_request(ACT_RESERVE, 16'd0, '0, '0, '0);
    send_request(ACT_RESERVE, 16'd1, '0, '0, '0);
    send_request(ACT_RESERVE, 16'd5, '0, '0, '0);     // aligns up from 1
    send_request(ACT_RESERVE, 16'hffff, '0, '0, '0);
    send_request(ACT_RESERVE, 16'd4084, '0, '0, '0);  // fills to the end
    send_request(ACT_RESERVE, 16'd0, '0, '0, '0);     // grant at the very end
    send_request(ACT_RESERVE, 16'd1, '0, '0, '0);
    send_request(ACT_REWIND, '0, '0, '0, 32'd5);
    send_request(ACT_SUBMIT, '0, 16'd0, 16'd0, '0);
    send_request(ACT_SUBMIT, '0, 16'd4095, 16'd2, '0);
    send_request(ACT_SUBMIT, '0, 16'd0, 16'd4096, '0);
    send_request(ACT_SUBMIT, '0, 16'd4095, 16'd1, '0);
    send_request(ACT_SUBMIT, '0, 16'hffff, 16'hffff, '0);
    send_request(ACT_SUBMIT, '0, 16'd3, 16'd5, '0);
    send_request(ACT_REWIND, '0, '0, '0, '0);
    send_request(ACT_REWIND, '0, '0, '0, sb.put_count);
    // empty pushbuffer: host_get is ignored
    send_request(ACT_REWIND, '0, '0, '0, 32'hffff_ffff);
    send_request(ACT_UNUSED, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff);
    wait_drained();

    // pushbuffer right at the top of the address window
    apply_config(1'b1, 48'h00ff_ffff_f800, 1'b0, '0);
    send_request(ACT_SUBMIT, '0, 16'd0, 16'd4, '0);
    send_request(ACT_SUBMIT, '0, 16'h07ff, 16'd1, '0);
    send_request(ACT_SUBMIT, '0, 16'h0800, 16'd4, '0);
    wait_drained();

    apply_config(1'b1, 48'hffff_ffff_ffff, 1'b1, $urandom);
    send_request(ACT_SUBMIT, '0, 16'd0, 16'd8, '0);
    send_request(ACT_SUBMIT, '0, 16'd0, 16'd0, '0);
    wait_drained();

    // receiver holds off while the sender keeps pushing back to back
    apply_config(1'b1, '0, 1'b1, $urandom);
    sink_hold_req = 1'b1;
    run_random(24, 40, 1'b0);
    run_random(226, 40, 1'b1);
    wait_drained();

    base = 48'({$urandom, $urandom});
    base[47:40] = '0;
    apply_config(1'b1, base, 1'b0, $urandom);
    run_random(250, 70, 1'b0);
    wait_drained();

    base = 48'h00ff_ffff_f000 + 48'($urandom_range(0, PB_BYTES_DFLT - 1));
    apply_config(1'b1, base, 1'($urandom_range(0, 1)), $urandom);
    run_random(200, 50, 1'b1);
    wait_drained();

    apply_config(1'b0, 48'({$urandom, $urandom}), 1'b1, $urandom);
    run_random(50, 35, 1'b1);
    wait_drained();

    apply_config(1'b1, 48'({$urandom, $urandom}), 1'b1, $urandom);
    run_random(100, 50, 1'b1);
    wait_drained();

    base = 48'({$urandom, $urandom});
    base[47:39] = '0;
    apply_config(1'b1, base, 1'b1, 32'd0);
    run_random(150, 55, 1'b1);
    wait_drained();   // sender waits for every result before going on
    run_random(150, 55, 1'b1);
    wait_drained();

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
